/* src/assert_macros.svh */
// Assertion shorthands shared by the RTL. Both sample on clk and are
// switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that, when seen, must be followed in the next cycle by another.
`define ASSERT_NEXT(label, cond, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (post)) \
		else $error(msg);

`endif

/* src/fdf_pkg.sv */
package fdf_pkg;

	localparam int SEQ_W   = 16;
	localparam int LVL_W   = 7;
	localparam int OWN_W   = 8;
	localparam int CNT_W   = 8;
	localparam int MARK_W  = 15;
	localparam int LIMIT_W = 7;
	localparam int IDX_W   = 8;

	localparam logic [MARK_W-1:0]  WRAP_HIGH_RST  = 15'd32000;
	localparam logic [MARK_W-1:0]  WRAP_LOW_RST   = 15'd1000;
	localparam logic [LIMIT_W-1:0] LEVEL_WAIT_RST = 7'd3;
	localparam logic [CNT_W-1:0]   SILENCE_RST    = 8'd3;
	localparam logic [SEQ_W-1:0]   NEWEST_RST     = '1;
	localparam logic [OWN_W-1:0]   LEVEL_UNKNOWN  = '1;
	localparam logic [LVL_W-1:0]   NO_LEVEL       = '1;

	typedef enum logic [IDX_W-1:0] {
		CFG_WRAP_HIGH  = 8'd0,
		CFG_WRAP_LOW   = 8'd1,
		CFG_LEVEL_WAIT = 8'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MARK_W-1:0]  wrap_high;
		logic [MARK_W-1:0]  wrap_low;
		logic [LIMIT_W-1:0] level_wait;
	} cfg_t;

	// Decision for one packet and the level-tracking state it leaves behind.
	typedef struct packed {
		logic                    fwd;
		logic                    newer;
		logic signed [OWN_W-1:0] node_level;
		logic [CNT_W-1:0]        silence_count;
	} decide_t;

endpackage

/* src/flood_duplicate_filter_level_track.sv */
// Flood duplicate filter with tree level tracking. Each request carries a packet's
// sequence number and its sender's tree level; the block answers with one result per
// request: whether the packet should be rebroadcast and the node's own tree level after
// it. A request is registered, decided against the newest sequence number, the recent
// history window and the level counters, and the result is registered for output.
// One request is taken every cycle unless a stalled output holds the decided request
// (in_stall); that rate is set by the update loop on the filter state. Configuration
// writes are always ready and should only be issued while no request is in flight.
`include "assert_macros.svh"

module flood_duplicate_filter_level_track #(
	parameter int WINDOW_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [fdf_pkg::SEQ_W-1:0]   seq_number,
	input  logic signed [fdf_pkg::LVL_W-1:0]   sender_level,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               forward_now,
	output logic signed [fdf_pkg::OWN_W-1:0]   own_level,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fdf_pkg::IDX_W-1:0]          cfg_index,
	input  logic [fdf_pkg::MARK_W-1:0]         cfg_data
);

	fdf_pkg::cfg_t                      cfg_q;
	logic                               valid_s1;
	logic signed [fdf_pkg::SEQ_W-1:0]   seq_s1;
	logic signed [fdf_pkg::LVL_W-1:0]   lvl_s1;
	logic signed [fdf_pkg::SEQ_W-1:0]   newest_q;
	logic [WINDOW_BITS-1:0]             window_q;
	logic signed [fdf_pkg::OWN_W-1:0]   node_level_q;
	logic [fdf_pkg::CNT_W-1:0]          silence_q;
	logic                               out_valid_q;
	logic                               forward_q;
	logic signed [fdf_pkg::OWN_W-1:0]   own_level_q;
	logic                               advance;
	logic                               commit;
	fdf_pkg::decide_t                   dec;
	logic signed [fdf_pkg::SEQ_W-1:0]   newest_nxt;
	logic [WINDOW_BITS-1:0]             window_nxt;
	fdf_pkg::cfg_reg_t                  cfg_reg;

	assign cfg_ready = 1'b1;
	assign cfg_reg   = fdf_pkg::cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrap_high  <= fdf_pkg::WRAP_HIGH_RST;
			cfg_q.wrap_low   <= fdf_pkg::WRAP_LOW_RST;
			cfg_q.level_wait <= fdf_pkg::LEVEL_WAIT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg)
				fdf_pkg::CFG_WRAP_HIGH:  cfg_q.wrap_high  <= cfg_data;
				fdf_pkg::CFG_WRAP_LOW:   cfg_q.wrap_low   <= cfg_data;
				fdf_pkg::CFG_LEVEL_WAIT: cfg_q.level_wait <= cfg_data[fdf_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// The decided request moves on whenever the result register is free or drained.
	assign advance  = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			seq_s1 <= seq_number;
			lvl_s1 <= sender_level;
		end
	end

	fdf_decide #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_decide (
		.cfg          (cfg_q),
		.seq          (seq_s1),
		.lvl          (lvl_s1),
		.newest       (newest_q),
		.window       (window_q),
		.node_level   (node_level_q),
		.silence_count(silence_q),
		.dec          (dec),
		.newest_nxt   (newest_nxt),
		.window_nxt   (window_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q     <= $signed(fdf_pkg::NEWEST_RST);
			window_q     <= '0;
			node_level_q <= $signed(fdf_pkg::LEVEL_UNKNOWN);
			silence_q    <= fdf_pkg::SILENCE_RST;
		end else if (commit) begin
			newest_q     <= newest_nxt;
			window_q     <= window_nxt;
			node_level_q <= dec.node_level;
			silence_q    <= dec.silence_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			forward_q   <= dec.fwd;
			own_level_q <= dec.node_level;
		end
	end

	assign out_valid   = out_valid_q;
	assign forward_now = forward_q;
	assign own_level   = own_level_q;

	`ASSERT_NEXT(a_newer_sets_head, commit && dec.newer, (newest_q == $past(seq_s1)) && window_q[0] && forward_q, "newer packet did not become the window head")
	`ASSERT_NEXT(a_dup_keeps_state, commit && !dec.fwd, $stable(newest_q) && $stable(window_q) && $stable(node_level_q) && $stable(silence_q), "duplicate packet changed filter state")
	`ASSERT_NEXT(a_result_level, commit, own_level_q == node_level_q, "reported level differs from tracked level")
	`ASSERT_ALWAYS(a_stall_only_when_full, in_stall == (valid_s1 && out_valid_q && out_stall), "input stalled without a full pipeline")

endmodule

/* src/fdf_decide.sv */
module fdf_decide #(
	parameter int WINDOW_BITS = 8
) (
	input  fdf_pkg::cfg_t                          cfg,
	input  logic signed [fdf_pkg::SEQ_W-1:0]       seq,
	input  logic signed [fdf_pkg::LVL_W-1:0]       lvl,
	input  logic signed [fdf_pkg::SEQ_W-1:0]       newest,
	input  logic [WINDOW_BITS-1:0]                 window,
	input  logic signed [fdf_pkg::OWN_W-1:0]       node_level,
	input  logic [fdf_pkg::CNT_W-1:0]              silence_count,
	output fdf_pkg::decide_t                       dec,
	output logic signed [fdf_pkg::SEQ_W-1:0]       newest_nxt,
	output logic [WINDOW_BITS-1:0]                 window_nxt
);

	logic                              wrap;
	logic signed [fdf_pkg::SEQ_W-1:0]  newest_eff;
	logic [WINDOW_BITS-1:0]            win_eff;
	logic [WINDOW_BITS-1:0]            win_shr;
	logic [fdf_pkg::SEQ_W-1:0]         gap;
	logic [fdf_pkg::SEQ_W-1:0]         shift;
	logic                              newer;
	logic                              in_range;
	logic                              fwd;
	logic                              has_lvl;
	logic                              parent;
	logic signed [fdf_pkg::OWN_W:0]    lvl_x;
	logic signed [fdf_pkg::OWN_W:0]    node_x;
	logic [fdf_pkg::CNT_W-1:0]         cnt_inc;
	logic                              adopt;

	// Wraparound: a high newest number and a low incoming one restart the window.
	assign wrap = (newest > $signed({1'b0, cfg.wrap_high}))
		&& (seq < $signed({1'b0, cfg.wrap_low}));
	assign newest_eff = wrap ? seq : newest;
	assign win_eff    = wrap ? '0 : window;

	assign gap      = newest_eff - seq;
	assign newer    = gap[fdf_pkg::SEQ_W-1];
	assign shift    = '0 - gap;
	assign in_range = !newer && (gap < fdf_pkg::SEQ_W'(WINDOW_BITS));
	assign win_shr  = win_eff >> gap;
	assign fwd      = newer || (in_range && !win_shr[0]);

	always_comb begin
		if (!fwd) begin
			window_nxt = win_eff;
			newest_nxt = newest_eff;
		end else if (newer) begin
			// A shift of the full width or more empties the window by itself.
			window_nxt = (win_eff << shift) | WINDOW_BITS'(1);
			newest_nxt = seq;
		end else begin
			window_nxt = win_eff | (WINDOW_BITS'(1) << gap);
			newest_nxt = newest_eff;
		end
	end

	assign has_lvl = (lvl != $signed(fdf_pkg::NO_LEVEL));
	assign lvl_x   = {{(fdf_pkg::OWN_W + 1 - fdf_pkg::LVL_W){lvl[fdf_pkg::LVL_W-1]}}, lvl};
	assign node_x  = {node_level[fdf_pkg::OWN_W-1], node_level};
	assign parent  = (lvl_x == node_x - 9'sd1);
	assign cnt_inc = silence_count + fdf_pkg::CNT_W'(1);
	assign adopt   = cnt_inc > {1'b0, cfg.level_wait};

	always_comb begin
		dec.fwd           = fwd;
		dec.newer         = newer;
		dec.node_level    = node_level;
		dec.silence_count = silence_count;
		if (fwd && has_lvl) begin
			if (parent) begin
				dec.silence_count = '0;
			end else if (adopt) begin
				// Sender levels stop at 63, so the new level never reaches saturation.
				dec.node_level    = lvl_x[fdf_pkg::OWN_W-1:0] + fdf_pkg::OWN_W'(1);
				dec.silence_count = '0;
			end else begin
				dec.silence_count = cnt_inc;
			end
		end
	end

endmodule

/* verif/tb.sv */
module tb;
	import fdf_pkg::*;

	localparam int WINDOW = 8;
	localparam int PHASE_PKTS = 200;
	localparam int N_PHASES = 8;
	// Index just past the last register; writes to it must leave every setting alone.
	localparam logic [IDX_W-1:0] CFG_UNUSED = 8'd3;

	typedef struct {
		logic                    fwd;
		logic signed [OWN_W-1:0] level;
	} verdict_t;

	typedef struct {
		logic signed [SEQ_W-1:0] seq;
		logic signed [LVL_W-1:0] lvl;
		bit                      typed;
		logic                    fwd;
		logic signed [OWN_W-1:0] level;
	} pkt_row_t;

	typedef struct {
		logic [MARK_W-1:0] high;
		logic [MARK_W-1:0] low;
		logic [MARK_W-1:0] wait_limit;
	} mark_set_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [SEQ_W-1:0]   seq_number;
	logic signed [LVL_W-1:0]   sender_level;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      forward_now;
	logic signed [OWN_W-1:0]   own_level;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [IDX_W-1:0]          cfg_index;
	logic [MARK_W-1:0]         cfg_data;

	// Mirror of the filter state and its settings.
	logic signed [SEQ_W-1:0]   m_newest;
	logic [WINDOW-1:0]         m_window;
	logic signed [OWN_W-1:0]   m_level;
	logic [CNT_W-1:0]          m_silence;
	logic [MARK_W-1:0]         m_high;
	logic [MARK_W-1:0]         m_low;
	logic [LIMIT_W-1:0]        m_wait;

	verdict_t verdict_q[$];
	int n_pkts, n_verdicts, n_fwd, n_wraps, n_adopt, n_cfg, n_err;
	int hold_left;
	bit hold_done;

	// Directed packets, run from the reset settings.
	pkt_row_t dir_rows [19] = '{
		'{0, -1, 1'b1, 1'b1, -1},
		'{0, -1, 1'b1, 1'b0, -1},
		'{1, -2, 1'b0, 1'b0, 0},
		'{7, -1, 1'b0, 1'b0, 0},
		'{0, -1, 1'b0, 1'b0, 0},
		'{2, -1, 1'b0, 1'b0, 0},
		'{15, 5, 1'b0, 1'b0, 0},
		'{16, 5, 1'b0, 1'b0, 0},
		'{17, 5, 1'b0, 1'b0, 0},
		'{18, 5, 1'b0, 1'b0, 0},
		'{7, 5, 1'b0, 1'b0, 0},
		'{14, 5, 1'b0, 1'b0, 0},
		'{32767, 63, 1'b0, 1'b0, 0},
		'{-32768, -64, 1'b0, 1'b0, 0},
		'{-32768, -2, 1'b0, 1'b0, 0},
		'{100, 0, 1'b0, 1'b0, 0},
		'{-32767, 63, 1'b0, 1'b0, 0},
		'{-1, -2, 1'b0, 1'b0, 0},
		'{0, -2, 1'b0, 1'b0, 0}
	};

	mark_set_t mark_sets [6] = '{
		'{15'd0, 15'd0, 15'd0},
		'{15'd32767, 15'd32767, 15'h7fff},
		'{15'd16000, 15'd20000, 15'd1},
		'{15'd100, 15'd32767, 15'd5},
		'{15'd32000, 15'd1000, 15'd2},
		'{15'd1, 15'd0, 15'h7f80}
	};

	flood_duplicate_filter_level_track #(
		.WINDOW_BITS(WINDOW)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seq_number  (seq_number),
		.sender_level(sender_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.forward_now (forward_now),
		.own_level   (own_level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("flood_duplicate_filter_level_track test failed");
		$finish;
	end

	// Both sides run without idling through this stretch of packets.
	function automatic bit calm_now();
		return n_pkts >= 900 && n_pkts < 1100;
	endfunction

	function automatic verdict_t decide_packet(logic signed [SEQ_W-1:0] seq,
			logic signed [LVL_W-1:0] lvl);
		verdict_t v;
		logic signed [SEQ_W-1:0] gap;
		int shift;
		int nl;
		if (m_newest > $signed({1'b0, m_high}) && seq < $signed({1'b0, m_low})) begin
			m_newest = seq;
			m_window = '0;
			n_wraps++;
		end
		gap = m_newest - seq;
		v.fwd = (gap < 0) || (gap < WINDOW && !m_window[gap[2:0]]);
		if (v.fwd) begin
			if (gap < 0) begin
				shift = -int'(gap);
				m_window = (shift >= WINDOW) ? '0 : m_window << shift;
				m_window[0] = 1'b1;
				m_newest = seq;
			end else begin
				m_window[gap[2:0]] = 1'b1;
			end
			if (lvl != NO_LEVEL) begin
				// The parent test is done on full integers, so an unknown level
				// of -1 takes a sender at -2 as its parent.
				if (int'(lvl) == int'(m_level) - 1) begin
					m_silence = '0;
				end else begin
					m_silence = m_silence + 1'b1;
					if (m_silence > {1'b0, m_wait}) begin
						nl = int'(lvl) + 1;
						if (nl > 127)
							nl = 127;
						m_level = OWN_W'(nl);
						m_silence = '0;
						n_adopt++;
					end
				end
			end
		end
		v.level = m_level;
		return v;
	endfunction

	function automatic logic signed [SEQ_W-1:0] pick_seq();
		int r;
		logic [SEQ_W-1:0] base;
		r = $urandom_range(0, 99);
		base = m_newest;
		if (r < 55)
			return base + SEQ_W'($urandom_range(0, 13)) - SEQ_W'(10);
		if (r < 62)
			return {1'b0, m_low} + SEQ_W'(1) - SEQ_W'($urandom_range(0, 3));
		if (r < 67)
			return {1'b0, m_high} + SEQ_W'($urandom_range(0, 3)) - SEQ_W'(1);
		if (r < 70)
			return SEQ_W'(0) - SEQ_W'($urandom_range(1, 40));
		if (r < 85)
			return base + SEQ_W'($urandom_range(8, 3000));
		return SEQ_W'($urandom);
	endfunction

	function automatic logic signed [LVL_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return LVL_W'(m_level - 8'sd1);
		if (r < 55)
			return NO_LEVEL;
		if (r < 70)
			return LVL_W'(m_level);
		return LVL_W'($urandom);
	endfunction

	task automatic offer_pkt(input logic signed [SEQ_W-1:0] seq,
			input logic signed [LVL_W-1:0] lvl, input bit typed,
			input logic tfwd, input logic signed [OWN_W-1:0] tlevel);
		verdict_t v;
		if (!calm_now() && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		seq_number <= seq;
		sender_level <= lvl;
		do @(posedge clk); while (in_stall);
		v = decide_packet(seq, lvl);
		if (typed) begin
			v.fwd = tfwd;
			v.level = tlevel;
		end
		if (v.fwd)
			n_fwd++;
		verdict_q.push_back(v);
		n_pkts++;
	endtask

	// Leaves cfg_valid high; the caller lowers it after its last write.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MARK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WRAP_HIGH: m_high = val;
			CFG_WRAP_LOW: m_low = val;
			CFG_LEVEL_WAIT: m_wait = val[LIMIT_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic wait_drained();
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		verdict_t v;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_verdicts++;
				if (verdict_q.size() == 0) begin
					n_err++;
					$error("result with no request pending: forward_now=%0b own_level=%0d",
						forward_now, own_level);
				end else begin
					v = verdict_q.pop_front();
					if (forward_now !== v.fwd) begin
						n_err++;
						$error("forward_now: expected %0b, got %0b", v.fwd, forward_now);
					end
					if (own_level !== v.level) begin
						n_err++;
						$error("own_level: expected %0d, got %0d", v.level, own_level);
					end
				end
			end
			// One long hold-off lets the block fill up and push back on its input.
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && n_verdicts >= 300) begin
				hold_done = 1'b1;
				hold_left = 79;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm_now() && $urandom_range(0, 99) < 12;
			end
		end
	end

	initial begin
		mark_set_t ms;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		seq_number <= '0;
		sender_level <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		m_newest = NEWEST_RST;
		m_window = '0;
		m_level = LEVEL_UNKNOWN;
		m_silence = SILENCE_RST;
		m_high = WRAP_HIGH_RST;
		m_low = WRAP_LOW_RST;
		m_wait = LEVEL_WAIT_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer_pkt(dir_rows[i].seq, dir_rows[i].lvl, dir_rows[i].typed,
				dir_rows[i].fwd, dir_rows[i].level);

		for (int p = 0; p < N_PHASES; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			if (p < $size(mark_sets))
				ms = mark_sets[p];
			else
				ms = '{MARK_W'($urandom_range(0, 32767)), MARK_W'($urandom_range(0, 32767)),
					MARK_W'($urandom_range(0, 127))};
			write_reg(CFG_WRAP_HIGH, ms.high);
			write_reg(CFG_WRAP_LOW, ms.low);
			write_reg(CFG_LEVEL_WAIT, ms.wait_limit);
			if (p % 2 == 1)
				write_reg(CFG_UNUSED, MARK_W'($urandom));
			cfg_valid <= 1'b0;
			for (int i = 0; i < PHASE_PKTS; i++)
				offer_pkt(pick_seq(), pick_level(), 1'b0, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d packets: %0d forwarded, %0d duplicates, %0d wraparounds.",
			n_verdicts, n_fwd, n_pkts - n_fwd, n_wraps);
		$display("Level adopted %0d times across %0d register writes.", n_adopt, n_cfg);
		if (n_err == 0)
			$display("flood_duplicate_filter_level_track test passed");
		else
			$display("flood_duplicate_filter_level_track test failed");
		$finish;
	end

endmodule

/* flood_duplicate_filter_level_track.f */
+incdir+src
src/fdf_pkg.sv
src/fdf_decide.sv
src/flood_duplicate_filter_level_track.sv
verif/tb.sv
